// ===== sv/smt_pkg.sv =====
package smt_pkg;

  localparam int CMD_BITS   = 2;
  localparam int CNT_BITS   = 16;
  localparam int TOTAL_BITS = 20;
  localparam int DIST_BITS  = 5;
  localparam int IN_BITS    = 32;

  localparam logic [CMD_BITS-1:0]   CMD_ADD    = 2'd0;
  localparam logic [CMD_BITS-1:0]   CMD_REMOVE = 2'd1;
  localparam logic [CMD_BITS-1:0]   CMD_QUERY  = 2'd2;

  localparam logic [CNT_BITS-1:0]   CNT_MAX    = 16'hFFFF;
  localparam logic [TOTAL_BITS-1:0] TOTAL_MAX  = 20'hFFFFF;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_INC,
    OP_DEC,
    OP_INS,
    OP_DEL
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_RED,
    ST_UPD
  } state_t;

  typedef struct packed {
    logic cmp_en;
    logic upd_en;
    op_t  op;
  } cell_ctl_t;

endpackage

// ===== sv/smt_if.sv =====
interface smt_req_if;
  logic                                valid;
  logic                                ready;
  logic        [smt_pkg::CMD_BITS-1:0] cmd;
  logic signed [smt_pkg::IN_BITS-1:0]  value;

  modport source (output valid, output cmd, output value, input ready);
  modport sink (input valid, input cmd, input value, output ready);
endinterface

interface smt_rsp_if;
  logic                            valid;
  logic                            ready;
  logic                            ok;
  logic [smt_pkg::CNT_BITS-1:0]    occurrences;
  logic [smt_pkg::TOTAL_BITS-1:0]  total;
  logic [smt_pkg::DIST_BITS-1:0]   distinct;

  modport source (output valid, output ok, output occurrences, output total,
                  output distinct, input ready);
  modport sink (input valid, input ok, input occurrences, input total,
                input distinct, output ready);
endinterface

// ===== sv/sorted_multiset_table.sv =====
// Channel  Dir  Fields                                  Handshake
// req      in   cmd[1:0], value[31:0] signed            valid/ready
// rsp      out  ok, occurrences[15:0], total[19:0],     valid/ready
//               distinct[4:0]
//
// Each word passes through accept, compare in every cell, hit/count reduce and
// decision, and cell update; no new word is accepted until the update is done.
// Sync reset clears cell valid bits, entry and element totals.
// Update waits while a previous result on rsp is not yet taken.
module sorted_multiset_table #(
  parameter int DEPTH      = 16,
  parameter int VALUE_BITS = 32
) (
  input  logic      clk,
  input  logic      rst,
  smt_req_if.sink   req,
  smt_rsp_if.source rsp
);
  import smt_pkg::*;

  localparam int UW = $clog2(DEPTH + 1);
  localparam int WB = (VALUE_BITS < IN_BITS) ? VALUE_BITS : IN_BITS;

  state_t state, state_next;
  cell_ctl_t ctl;

  logic        [CMD_BITS-1:0]   cmd_r;
  logic signed [VALUE_BITS-1:0] key;
  logic signed [WB-1:0]         v_low;
  logic        [UW-1:0]         used;
  logic        [TOTAL_BITS-1:0] total;
  op_t                          op_r;
  logic                         res_ok;
  logic        [CNT_BITS-1:0]   res_occ;

  logic                         o_valid;
  logic                         o_ok;
  logic        [CNT_BITS-1:0]   o_occ;
  logic        [TOTAL_BITS-1:0] o_total;
  logic        [DIST_BITS-1:0]  o_dist;

  logic                         c_valid [DEPTH];
  logic signed [VALUE_BITS-1:0] c_value [DEPTH];
  logic        [CNT_BITS-1:0]   c_count [DEPTH];
  logic                         c_gt    [DEPTH];
  logic                         c_eq    [DEPTH];

  logic                         hit;
  logic        [CNT_BITS-1:0]   hit_cnt;
  op_t                          dec_op;
  logic                         dec_ok;
  logic        [CNT_BITS-1:0]   dec_occ;
  logic        [UW-1:0]         dec_used;
  logic        [TOTAL_BITS-1:0] dec_total;
  logic                         fire;

  assign v_low = req.value[WB-1:0];

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      logic                         lv, lg, rv;
      logic signed [VALUE_BITS-1:0] lval, rval;
      logic        [CNT_BITS-1:0]   lcnt, rcnt;

      if (g == 0) begin : g_first
        assign lv   = 1'b0;
        assign lval = '0;
        assign lcnt = '0;
        assign lg   = 1'b0;
      end else begin : g_mid
        assign lv   = c_valid[g-1];
        assign lval = c_value[g-1];
        assign lcnt = c_count[g-1];
        assign lg   = c_gt[g-1];
      end

      if (g == DEPTH - 1) begin : g_last
        assign rv   = 1'b0;
        assign rval = '0;
        assign rcnt = '0;
      end else begin : g_inner
        assign rv   = c_valid[g+1];
        assign rval = c_value[g+1];
        assign rcnt = c_count[g+1];
      end

      smt_cell #(.VALUE_BITS(VALUE_BITS)) u_cell (
        .clk         (clk),
        .rst         (rst),
        .ctl         (ctl),
        .key         (key),
        .left_valid  (lv),
        .left_value  (lval),
        .left_count  (lcnt),
        .left_gt     (lg),
        .right_valid (rv),
        .right_value (rval),
        .right_count (rcnt),
        .valid       (c_valid[g]),
        .value       (c_value[g]),
        .count       (c_count[g]),
        .gt          (c_gt[g]),
        .eq          (c_eq[g])
      );
    end
  endgenerate

  // at most one cell matches
  always_comb begin
    hit     = 1'b0;
    hit_cnt = '0;
    for (int i = 0; i < DEPTH; i++) begin
      hit     = hit | c_eq[i];
      hit_cnt = hit_cnt | (c_eq[i] ? c_count[i] : '0);
    end
  end

  always_comb begin
    dec_op    = OP_NONE;
    dec_ok    = 1'b0;
    dec_occ   = '0;
    dec_used  = used;
    dec_total = total;
    case (cmd_r)
      CMD_ADD: begin
        if (hit) begin
          dec_occ = hit_cnt;
          if (hit_cnt < CNT_MAX && total < TOTAL_MAX) begin
            dec_op    = OP_INC;
            dec_ok    = 1'b1;
            dec_occ   = hit_cnt + CNT_BITS'(1);
            dec_total = total + TOTAL_BITS'(1);
          end
        end else if (used < UW'(DEPTH) && total < TOTAL_MAX) begin
          dec_op    = OP_INS;
          dec_ok    = 1'b1;
          dec_occ   = CNT_BITS'(1);
          dec_used  = used + UW'(1);
          dec_total = total + TOTAL_BITS'(1);
        end
      end
      CMD_REMOVE: begin
        if (hit) begin
          dec_ok = 1'b1;
          if (hit_cnt > CNT_BITS'(1)) begin
            dec_op  = OP_DEC;
            dec_occ = hit_cnt - CNT_BITS'(1);
          end else begin
            dec_op   = OP_DEL;
            dec_used = used - UW'(1);
          end
          if (total != '0) dec_total = total - TOTAL_BITS'(1);
        end
      end
      CMD_QUERY: begin
        if (hit) begin
          dec_ok  = 1'b1;
          dec_occ = hit_cnt;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (req.valid) state_next = ST_CMP;
      ST_CMP:  state_next = ST_RED;
      ST_RED:  state_next = ST_UPD;
      ST_UPD:  if (!o_valid || rsp.ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req.ready  = (state == ST_IDLE);
    fire       = (state == ST_UPD) && (!o_valid || rsp.ready);
    ctl.cmp_en = (state == ST_CMP);
    ctl.upd_en = fire;
    ctl.op     = op_r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      used    <= '0;
      total   <= '0;
      o_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_RED) begin
        used  <= dec_used;
        total <= dec_total;
      end
      if (fire) begin
        o_valid <= 1'b1;
      end else if (rsp.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      cmd_r <= req.cmd;
      key   <= VALUE_BITS'(v_low);
    end
    if (state == ST_RED) begin
      op_r    <= dec_op;
      res_ok  <= dec_ok;
      res_occ <= dec_occ;
    end
    if (fire) begin
      o_ok    <= res_ok;
      o_occ   <= res_occ;
      o_total <= total;
      o_dist  <= DIST_BITS'(used);
    end
  end

  assign rsp.valid       = o_valid;
  assign rsp.ok          = o_ok;
  assign rsp.occurrences = o_occ;
  assign rsp.total       = o_total;
  assign rsp.distinct    = o_dist;

endmodule

// ===== sv/smt_cell.sv =====
module smt_cell #(
  parameter int VALUE_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  smt_pkg::cell_ctl_t                  ctl,
  input  logic signed [VALUE_BITS-1:0]        key,
  input  logic                                left_valid,
  input  logic signed [VALUE_BITS-1:0]        left_value,
  input  logic        [smt_pkg::CNT_BITS-1:0] left_count,
  input  logic                                left_gt,
  input  logic                                right_valid,
  input  logic signed [VALUE_BITS-1:0]        right_value,
  input  logic        [smt_pkg::CNT_BITS-1:0] right_count,
  output logic                                valid,
  output logic signed [VALUE_BITS-1:0]        value,
  output logic        [smt_pkg::CNT_BITS-1:0] count,
  output logic                                gt,
  output logic                                eq
);
  import smt_pkg::*;

  // gt: slot at or past the sorted place of key (empty slots count as past)
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      gt    <= 1'b0;
      eq    <= 1'b0;
    end else if (ctl.cmp_en) begin
      gt <= !valid || (value >= key);
      eq <= valid && (value == key);
    end else if (ctl.upd_en) begin
      case (ctl.op)
        OP_INC: begin
          if (eq) count <= count + CNT_BITS'(1);
        end
        OP_DEC: begin
          if (eq) count <= count - CNT_BITS'(1);
        end
        OP_INS: begin
          if (gt) begin
            if (left_gt) begin
              valid <= left_valid;
              value <= left_value;
              count <= left_count;
            end else begin
              valid <= 1'b1;
              value <= key;
              count <= CNT_BITS'(1);
            end
          end
        end
        OP_DEL: begin
          if (gt) begin
            valid <= right_valid;
            value <= right_value;
            count <= right_count;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule
